[rtl/core/educational_isa_cpu_core_defines.svh]
// Assertion helpers used by the core's controller.
`ifndef EDUCATIONAL_ISA_CPU_CORE_DEFINES_SVH
`define EDUCATIONAL_ISA_CPU_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EIC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("core assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define EIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("core assertion failed");

`endif

[rtl/core/eic_pkg.sv]
`timescale 1ns / 1ps

package eic_pkg;

  // Address space: default and largest supported width, and the width of
  // the command address and program counter ports.
  localparam int unsigned DefAddrBits = 12;
  localparam int unsigned MaxAddrBits = 17;
  localparam int unsigned PortAddrW   = 12;

  localparam logic [31:0] ClampMax = 32'h0000_7fff;

  // Three-valued flag codes.
  localparam logic [1:0] FLAG_FALSE = 2'd0;
  localparam logic [1:0] FLAG_TRUE  = 2'd1;
  localparam logic [1:0] FLAG_UNDEF = 2'd2;

  // Branch condition codes.
  localparam logic [2:0] COND_EQ     = 3'd0;
  localparam logic [2:0] COND_NE     = 3'd1;
  localparam logic [2:0] COND_GT     = 3'd2;
  localparam logic [2:0] COND_NOT_GT = 3'd3;
  localparam logic [2:0] COND_ALWAYS = 3'd4;

  // Host command codes.
  typedef enum logic [2:0] {
    CMD_STEP      = 3'd0,
    CMD_WRITE_MEM = 3'd1,
    CMD_READ_MEM  = 3'd2,
    CMD_SET_PC    = 3'd3,
    CMD_READ_REG  = 3'd4
  } cmd_e;

  // Instruction operation codes.
  typedef enum logic [3:0] {
    OP_LDR  = 4'd0,
    OP_STR  = 4'd1,
    OP_MOV  = 4'd2,
    OP_ADD  = 4'd3,
    OP_SUB  = 4'd4,
    OP_AND  = 4'd5,
    OP_ORR  = 4'd6,
    OP_EOR  = 4'd7,
    OP_MVN  = 4'd8,
    OP_LSL  = 4'd9,
    OP_LSR  = 4'd10,
    OP_CMP  = 4'd11,
    OP_B    = 4'd12,
    OP_HALT = 4'd13,
    OP_TRAP = 4'd14,
    OP_RSVD = 4'd15
  } op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EXEC,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic decode;
    logic exec;
    logic load_result;
  } ctl_t;

  // Saturate results that exceed the positive clamp limit.
  function automatic logic [31:0] clamp_hi(logic [31:0] x);
    return ($signed(x) > $signed(ClampMax)) ? ClampMax : x;
  endfunction

endpackage

[rtl/core/eic_controller.sv]
`timescale 1ns / 1ps
`include "educational_isa_cpu_core_defines.svh"

module eic_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [2:0]    opcode_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output eic_pkg::ctl_t cmd_o
);
  import eic_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  // The result register is free when empty or being emptied this cycle.
  assign slot_free = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && (state_q == ST_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (opcode_i == CMD_STEP) ? ST_DECODE : ST_FINISH;
        end
      end
      ST_DECODE: state_d = ST_EXEC;
      ST_EXEC:   state_d = ST_FINISH;
      ST_FINISH: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // Outputs to the handshake and the datapath.
  always_comb begin
    in_ready_o        = (state_q == ST_IDLE);
    cmd_o.accept      = accept;
    cmd_o.decode      = (state_q == ST_DECODE);
    cmd_o.exec        = (state_q == ST_EXEC);
    cmd_o.load_result = (state_q == ST_FINISH) && slot_free;
  end

  // Result beat valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // A step runs through decode after it is taken.
  `EIC_ASSERT_NEXT(a_step_decodes, clk_i, rst_ni, accept && (opcode_i == CMD_STEP), state_q == ST_DECODE)
  // A waiting result is never overwritten.
  `EIC_ASSERT_IMPLIES(a_no_overwrite, clk_i, rst_ni, out_valid_q && !out_ready_i, !cmd_o.load_result)
  // A loaded result is offered in the next cycle.
  `EIC_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, cmd_o.load_result, out_valid_q)

endmodule

[rtl/core/eic_datapath.sv]
`timescale 1ns / 1ps

module eic_datapath #(
  parameter int unsigned ADDR_BITS = eic_pkg::DefAddrBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  eic_pkg::ctl_t                cmd_i,
  input  logic [2:0]                   opcode_i,
  input  logic [eic_pkg::PortAddrW-1:0] address_i,
  input  logic signed [31:0]           data_i,
  input  logic [2:0]                   reg_index_i,
  output logic signed [31:0]           read_data_o,
  output logic [eic_pkg::PortAddrW-1:0] pc_o,
  output logic                         halted_o,
  output logic [1:0]                   eq_flag_o,
  output logic [1:0]                   gt_flag_o
);
  import eic_pkg::*;

  localparam int unsigned MemWords = 1 << ADDR_BITS;

  // Main memory and register file.
  logic [31:0]          mem [MemWords];
  logic [31:0]          mem_rdata_q;
  logic [31:0]          rf [8];
  logic [7:0]           rf_valid_q;
  logic [31:0]          rf_a_q, rf_b_q;

  // Architectural and sequencing state.
  logic [ADDR_BITS-1:0] pc_q;
  logic [1:0]           eq_q, gt_q;
  logic                 halt_q;
  logic [2:0]           cmd_q;
  logic [23:0]          ir_q;

  // Address views.
  logic [MaxAddrBits-1:0] cmd_addr_wide, pc_wide;
  logic [ADDR_BITS-1:0]   cmd_addr;

  assign cmd_addr_wide = MaxAddrBits'(address_i);
  assign cmd_addr      = cmd_addr_wide[ADDR_BITS-1:0];
  assign pc_wide       = MaxAddrBits'(pc_q);

  // Fields of the word being decoded, straight from the memory read data.
  op_e                  dec_op;
  logic [2:0]           dec_rd, dec_rn, dec_rt;
  logic [ADDR_BITS-1:0] dec_maddr;

  assign dec_op    = op_e'(mem_rdata_q[23:20]);
  assign dec_rd    = mem_rdata_q[19:17];
  assign dec_rn    = mem_rdata_q[16:14];
  assign dec_rt    = mem_rdata_q[2:0];
  assign dec_maddr = mem_rdata_q[ADDR_BITS-1:0];

  // Fields of the latched instruction during execute.
  op_e                  ex_op;
  logic [2:0]           ex_rd;
  logic [ADDR_BITS-1:0] ex_maddr;
  logic [31:0]          op_a, op_b;

  assign ex_op    = op_e'(ir_q[23:20]);
  assign ex_rd    = ir_q[19:17];
  assign ex_maddr = ir_q[ADDR_BITS-1:0];
  assign op_a     = rf_a_q;
  assign op_b     = ir_q[13] ? {19'b0, ir_q[12:0]} : rf_b_q;

  // Execute: register write-back value, flags and branch decision.
  logic        rf_we;
  logic [31:0] rf_wdata;
  logic        cmp_we, branch_take, shift_out;

  assign shift_out = |op_b[31:5];

  always_comb begin
    rf_we       = 1'b0;
    rf_wdata    = '0;
    cmp_we      = 1'b0;
    branch_take = 1'b0;
    unique case (ex_op)
      OP_LDR: begin rf_we = 1'b1; rf_wdata = mem_rdata_q; end
      OP_MOV: begin rf_we = 1'b1; rf_wdata = op_b; end
      OP_ADD: begin rf_we = 1'b1; rf_wdata = clamp_hi(op_a + op_b); end
      OP_SUB: begin rf_we = 1'b1; rf_wdata = op_a - op_b; end
      OP_AND: begin rf_we = 1'b1; rf_wdata = op_a & op_b; end
      OP_ORR: begin rf_we = 1'b1; rf_wdata = clamp_hi(op_a | op_b); end
      OP_EOR: begin rf_we = 1'b1; rf_wdata = op_a ^ op_b; end
      OP_MVN: begin rf_we = 1'b1; rf_wdata = ~op_b; end
      OP_LSL: begin
        rf_we    = 1'b1;
        rf_wdata = clamp_hi(shift_out ? 32'd0 : (op_a << op_b[4:0]));
      end
      OP_LSR: begin
        rf_we    = 1'b1;
        rf_wdata = shift_out ? 32'd0 : (op_a >> op_b[4:0]);
      end
      OP_CMP: cmp_we = 1'b1;
      OP_B: begin
        unique case (ex_rd)
          COND_EQ:     branch_take = (eq_q == FLAG_TRUE);
          COND_NE:     branch_take = (eq_q != FLAG_TRUE);
          COND_GT:     branch_take = (gt_q == FLAG_TRUE);
          COND_NOT_GT: branch_take = (gt_q == FLAG_FALSE);
          COND_ALWAYS: branch_take = 1'b1;
          default:     branch_take = 1'b0;
        endcase
      end
      OP_STR, OP_HALT, OP_TRAP, OP_RSVD: ;
    endcase
  end

  // Memory port control: host access on accept, fetch on a step, data
  // read during decode and store during execute.
  logic                 mem_we, mem_re;
  logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
  logic [31:0]          mem_wdata;

  always_comb begin
    mem_we    = (cmd_i.accept && (opcode_i == CMD_WRITE_MEM)) ||
                (cmd_i.exec && (ex_op == OP_STR));
    mem_waddr = cmd_i.accept ? cmd_addr : ex_maddr;
    mem_wdata = cmd_i.accept ? data_i : rf_a_q;
    mem_re    = (cmd_i.accept && ((opcode_i == CMD_STEP) || (opcode_i == CMD_READ_MEM))) ||
                cmd_i.decode;
    if (cmd_i.decode) begin
      mem_raddr = dec_maddr;
    end else if (opcode_i == CMD_STEP) begin
      mem_raddr = pc_q;
    end else begin
      mem_raddr = cmd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  // Register file reads: port A serves rn, or rd for stores and compares,
  // or the host's register read; port B serves rt.
  logic       rf_re_a;
  logic [2:0] rf_raddr_a;

  assign rf_re_a    = (cmd_i.accept && (opcode_i == CMD_READ_REG)) || cmd_i.decode;
  assign rf_raddr_a = !cmd_i.decode ? reg_index_i :
                      ((dec_op == OP_STR) || (dec_op == OP_CMP)) ? dec_rd : dec_rn;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && rf_we) begin
      rf[ex_rd] <= rf_wdata;
    end
    if (rf_re_a) begin
      rf_a_q <= rf_valid_q[rf_raddr_a] ? rf[rf_raddr_a] : 32'd0;
    end
    if (cmd_i.decode) begin
      rf_b_q <= rf_valid_q[dec_rt] ? rf[dec_rt] : 32'd0;
    end
  end

  // Registers never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q <= '0;
    end else if (cmd_i.exec && rf_we) begin
      rf_valid_q[ex_rd] <= 1'b1;
    end
  end

  // Program counter, flags and halt mark.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      eq_q   <= FLAG_UNDEF;
      gt_q   <= FLAG_UNDEF;
      halt_q <= 1'b0;
    end else begin
      if (cmd_i.accept && (opcode_i == CMD_SET_PC)) begin
        pc_q <= cmd_addr;
      end else if (cmd_i.decode) begin
        pc_q <= pc_q + 1'b1;
      end else if (cmd_i.exec && branch_take) begin
        pc_q <= ex_maddr;
      end
      if (cmd_i.exec) begin
        halt_q <= (ex_op == OP_HALT);
        if (cmp_we) begin
          eq_q <= (op_a == op_b) ? FLAG_TRUE : FLAG_FALSE;
          gt_q <= ($signed(op_a) > $signed(op_b)) ? FLAG_TRUE : FLAG_FALSE;
        end
      end
    end
  end

  // Command and instruction holding registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= opcode_i;
    end
    if (cmd_i.decode) begin
      ir_q <= mem_rdata_q[23:0];
    end
  end

  // Result register.
  logic [31:0] res_data;

  always_comb begin
    if (cmd_q == CMD_READ_MEM) begin
      res_data = mem_rdata_q;
    end else if (cmd_q == CMD_READ_REG) begin
      res_data = rf_a_q;
    end else begin
      res_data = 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      read_data_o <= res_data;
      pc_o        <= pc_wide[PortAddrW-1:0];
      halted_o    <= (cmd_q == CMD_STEP) && halt_q;
      eq_flag_o   <= eq_q;
      gt_flag_o   <= gt_q;
    end
  end

endmodule

[rtl/core/educational_isa_cpu_core.sv]
`timescale 1ns / 1ps
// Small processor core for a 24-bit instruction set with a host command
// port: each input beat is one command (step one instruction, write or read
// a memory word, set the program counter, read a register) and yields one
// result beat with the read word, the program counter and the flags. A step
// goes through acceptance with the instruction fetch, decode with the data
// read, execute and write-back, and the result load, in an order set by the
// single read port of the main memory and the registered register file
// reads. The other commands go from acceptance straight to the result load.
// Each result beat is offered in the cycle after its load. Memory contents
// are undefined until written; registers reset to zero and the eq and gt
// flags to the undefined code. A new command is taken once the previous
// one has loaded its result, even while that result still waits to be
// collected; a result that cannot be loaded because the one before it is
// still waiting holds the core.
module educational_isa_cpu_core #(
  parameter int unsigned ADDR_BITS = eic_pkg::DefAddrBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    opcode_i,
  input  logic [eic_pkg::PortAddrW-1:0] address_i,
  input  logic signed [31:0]            data_i,
  input  logic [2:0]                    reg_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            read_data_o,
  output logic [eic_pkg::PortAddrW-1:0] pc_o,
  output logic                          halted_o,
  output logic [1:0]                    eq_flag_o,
  output logic [1:0]                    gt_flag_o
);
  import eic_pkg::*;

  ctl_t ctl;

  // Sequencing of each command.
  eic_controller u_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (opcode_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (ctl)
  );

  // Memory, registers, execute logic and result register.
  eic_datapath #(
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctl),
    .opcode_i    (opcode_i),
    .address_i   (address_i),
    .data_i      (data_i),
    .reg_index_i (reg_index_i),
    .read_data_o (read_data_o),
    .pc_o        (pc_o),
    .halted_o    (halted_o),
    .eq_flag_o   (eq_flag_o),
    .gt_flag_o   (gt_flag_o)
  );

endmodule

[dv/educational_isa_cpu_core_checker.sv]
`timescale 1ns / 1ps

module educational_isa_cpu_core_checker #(
  parameter int unsigned AddrBits = eic_pkg::DefAddrBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [2:0]                    opcode_i,
  input  logic [eic_pkg::PortAddrW-1:0] address_i,
  input  logic [31:0]                   data_i,
  input  logic [2:0]                    reg_index_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [31:0]                   read_data_i,
  input  logic [eic_pkg::PortAddrW-1:0] pc_i,
  input  logic                          halted_i,
  input  logic [1:0]                    eq_flag_i,
  input  logic [1:0]                    gt_flag_i,
  output int unsigned                   fault_count_o,
  output int unsigned                   backlog_o
);

  import eic_pkg::*;

  localparam int unsigned MemWords = 1 << AddrBits;

  // One result beat as the core should present it.
  typedef struct packed {
    logic [31:0]          word;
    logic [PortAddrW-1:0] pc;
    logic                 halted;
    logic [1:0]           eq;
    logic [1:0]           gt;
  } core_result_t;

  // Shadow copy of the architectural state.
  logic [31:0]         mem_image [MemWords];
  logic [31:0]         reg_image [8];
  logic [AddrBits-1:0] pc_image;
  logic [1:0]          eq_image;
  logic [1:0]          gt_image;

  core_result_t        pending_results [$];
  int unsigned         results_seen;

  task automatic report_fault(input string msg);
    $display("%0t ns: result %0d: %s", $time, results_seen, msg);
    fault_count_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_fault($sformatf("%s is %h, expected %h", name, got, want));
    end
  endtask

  // Positive results above the clamp limit saturate; negative ones pass.
  function automatic logic [31:0] saturate_pos(input logic [31:0] x);
    if (!x[31] && x > ClampMax) begin
      return ClampMax;
    end
    return x;
  endfunction

  // Fetch, decode and execute the instruction at the program counter.
  task automatic run_one_step(output logic halted);
    logic [31:0]         ir;
    logic [31:0]         lhs;
    logic [31:0]         rhs;
    op_e                 op;
    logic [2:0]          rd;
    logic [2:0]          rn;
    logic [2:0]          rt;
    logic [AddrBits-1:0] target;
    logic                take;
    ir       = mem_image[pc_image];
    pc_image = pc_image + 1'b1;
    op       = op_e'(ir[23:20]);
    rd       = ir[19:17];
    rn       = ir[16:14];
    rt       = ir[2:0];
    target   = ir[AddrBits-1:0];
    lhs      = reg_image[rn];
    rhs      = ir[13] ? {19'd0, ir[12:0]} : reg_image[rt];
    halted   = 1'b0;
    take     = 1'b0;
    case (op)
      OP_LDR: reg_image[rd] = mem_image[target];
      OP_STR: mem_image[target] = reg_image[rd];
      OP_MOV: reg_image[rd] = rhs;
      OP_ADD: reg_image[rd] = saturate_pos(lhs + rhs);
      OP_SUB: reg_image[rd] = lhs - rhs;
      OP_AND: reg_image[rd] = lhs & rhs;
      OP_ORR: reg_image[rd] = saturate_pos(lhs | rhs);
      OP_EOR: reg_image[rd] = lhs ^ rhs;
      OP_MVN: reg_image[rd] = ~rhs;
      OP_LSL: reg_image[rd] = saturate_pos((rhs >= 32) ? 32'd0 : (lhs << rhs));
      OP_LSR: reg_image[rd] = (rhs >= 32) ? 32'd0 : (lhs >> rhs);
      OP_CMP: begin
        eq_image = (reg_image[rd] == rhs) ? FLAG_TRUE : FLAG_FALSE;
        gt_image = ($signed(reg_image[rd]) > $signed(rhs)) ? FLAG_TRUE : FLAG_FALSE;
      end
      OP_B: begin
        // An undefined flag satisfies neither a test for true nor for false; NE, a test for not true, takes it.
        case (rd)
          COND_EQ:     take = (eq_image == FLAG_TRUE);
          COND_NE:     take = (eq_image != FLAG_TRUE);
          COND_GT:     take = (gt_image == FLAG_TRUE);
          COND_NOT_GT: take = (gt_image == FLAG_FALSE);
          COND_ALWAYS: take = 1'b1;
          default:     take = 1'b0;
        endcase
        if (take) begin
          pc_image = target;
        end
      end
      OP_HALT: halted = 1'b1;
      default: ;
    endcase
  endtask

  // Apply one command beat to the shadow state and form its result.
  task automatic apply_command(input logic [2:0] cmd, input logic [PortAddrW-1:0] addr,
                               input logic [31:0] wdata, input logic [2:0] ridx,
                               output core_result_t res);
    logic halted;
    res = '0;
    case (cmd)
      CMD_STEP: begin
        run_one_step(halted);
        res.halted = halted;
      end
      CMD_WRITE_MEM: mem_image[AddrBits'(addr)] = wdata;
      CMD_READ_MEM:  res.word = mem_image[AddrBits'(addr)];
      CMD_SET_PC:    pc_image = AddrBits'(addr);
      CMD_READ_REG:  res.word = reg_image[ridx];
      default: ;
    endcase
    res.pc = PortAddrW'(pc_image);
    res.eq = eq_image;
    res.gt = gt_image;
  endtask

  // Results are compared before commands are taken in, so that a result
  // can never be matched against the command accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin : track
    core_result_t got;
    core_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        reg_image[i] = '0;
      end
      for (int i = 0; i < MemWords; i++) begin
        mem_image[i] = '0;
      end
      pc_image = '0;
      eq_image = FLAG_UNDEF;
      gt_image = FLAG_UNDEF;
      pending_results.delete();
      results_seen = 0;
      backlog_o   <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{word: read_data_i, pc: pc_i, halted: halted_i, eq: eq_flag_i,
                gt: gt_flag_i};
        if (pending_results.size() == 0) begin
          report_fault("result beat with no command outstanding");
        end else begin
          want = pending_results.pop_front();
          check_field("read_data", got.word, want.word);
          check_field("pc", 32'(got.pc), 32'(want.pc));
          check_field("halted", 32'(got.halted), 32'(want.halted));
          check_field("eq_flag", 32'(got.eq), 32'(want.eq));
          check_field("gt_flag", 32'(got.gt), 32'(want.gt));
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        apply_command(opcode_i, address_i, data_i, reg_index_i, want);
        pending_results.push_back(want);
      end
      backlog_o <= pending_results.size();
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  import eic_pkg::*;

  localparam int unsigned AddrBits      = DefAddrBits;
  localparam int unsigned MemWords      = 1 << AddrBits;
  localparam int unsigned OpeningLen    = 20;
  localparam int unsigned OpeningSteps  = 17;
  // Program area at the bottom of memory and data area at the top.
  localparam int unsigned ProgWords     = 128;
  localparam int unsigned DataWords     = 64;
  localparam int unsigned DataBase      = MemWords - DataWords;
  localparam int unsigned FillBeats     = ProgWords + DataWords;
  localparam int unsigned RandomBeats   = 1250;
  localparam int unsigned SqueezeAt     = FillBeats + 400;
  localparam int unsigned SqueezeCycles = 300;
  localparam int unsigned DrainCycles   = 20;

  // Command codes the core does not define; they must leave state alone.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [2:0]           opcode_i;
  logic [PortAddrW-1:0] address_i;
  logic signed [31:0]   data_i;
  logic [2:0]           reg_index_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [31:0]   read_data_o;
  logic [PortAddrW-1:0] pc_o;
  logic                 halted_o;
  logic [1:0]           eq_flag_o;
  logic [1:0]           gt_flag_o;

  int unsigned          fault_count;
  int unsigned          backlog;
  int unsigned          accepted_beats;
  int unsigned          burst_left;

  educational_isa_cpu_core #(
    .ADDR_BITS(AddrBits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .address_i  (address_i),
    .data_i     (data_i),
    .reg_index_i(reg_index_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .read_data_o(read_data_o),
    .pc_o       (pc_o),
    .halted_o   (halted_o),
    .eq_flag_o  (eq_flag_o),
    .gt_flag_o  (gt_flag_o)
  );

  educational_isa_cpu_core_checker #(
    .AddrBits(AddrBits)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .opcode_i     (opcode_i),
    .address_i    (address_i),
    .data_i       (data_i),
    .reg_index_i  (reg_index_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_i  (read_data_o),
    .pc_i         (pc_o),
    .halted_i     (halted_o),
    .eq_flag_i    (eq_flag_o),
    .gt_flag_i    (gt_flag_o),
    .fault_count_o(fault_count),
    .backlog_o    (backlog)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #20_000_000;
    $display("educational_isa_cpu_core test failed");
    $finish;
  end

  // Instruction words: register and immediate forms, and address forms.
  function automatic logic [31:0] alu_word(input op_e op, input logic [2:0] rd,
                                           input logic [2:0] rn, input logic use_imm,
                                           input logic [12:0] operand);
    return {8'h00, op, rd, rn, use_imm, operand};
  endfunction

  function automatic logic [31:0] addr_word(input op_e op, input logic [2:0] sel,
                                            input logic [16:0] target);
    return {8'h00, op, sel, target};
  endfunction

  // Random word address inside the data area.
  function automatic int unsigned data_slot();
    return DataBase + $urandom_range(0, DataWords - 1);
  endfunction

  // Address fields that land in the program or data area once wrapped; the
  // bits above the address width are random.
  function automatic logic [16:0] prog_target();
    return 17'($urandom_range(0, ProgWords - 2)) | 17'($urandom() << AddrBits);
  endfunction

  function automatic logic [16:0] data_target();
    return 17'(data_slot()) | 17'($urandom() << AddrBits);
  endfunction

  // Straight-line program run right after reset, while both flags are still
  // undefined. It covers branches on undefined flags, the clamp, wrapping
  // add, huge and exact shift amounts, address wrap and a step after HALT.
  function automatic logic [31:0] opening_word(input int unsigned slot);
    case (slot)
      0:  return addr_word(OP_B, COND_NE, 17'd2);
      2:  return addr_word(OP_B, COND_GT, 17'h00040);
      3:  return alu_word(OP_MOV, 3'd1, 3'd0, 1'b1, 13'h1fff);
      4:  return alu_word(OP_LSL, 3'd3, 3'd1, 1'b1, 13'd19);
      5:  return alu_word(OP_MVN, 3'd4, 3'd0, 1'b1, 13'd0);
      6:  return alu_word(OP_LSR, 3'd6, 3'd4, 1'b1, 13'd1);
      7:  return alu_word(OP_ADD, 3'd7, 3'd6, 1'b1, 13'd1);
      8:  return alu_word(OP_LSL, 3'd2, 3'd1, 1'b0, 13'd4);
      9:  return alu_word(OP_ORR, 3'd5, 3'd6, 1'b1, 13'd0);
      10: return alu_word(OP_CMP, 3'd7, 3'd0, 1'b0, 13'd6);
      11: return addr_word(OP_B, COND_NOT_GT, 17'h1f00d);
      13: return addr_word(OP_STR, 3'd7, 17'h1ffff);
      14: return addr_word(OP_LDR, 3'd0, 17'h00fff);
      15: return alu_word(OP_CMP, 3'd6, 3'd0, 1'b1, 13'h1fff);
      16: return addr_word(OP_B, COND_GT, 17'd18);
      19: return addr_word(OP_TRAP, 3'd0, 17'd0);
      default: return addr_word(OP_HALT, 3'd0, 17'd0);
    endcase
  endfunction

  // Random instruction with small immediates now and then so that shifts
  // and compares see interesting operands. Branches stay in the program
  // area and loads and stores in the data area.
  function automatic logic [31:0] random_word();
    op_e         op;
    logic [31:0] w;
    logic [12:0] operand;
    op = op_e'($urandom_range(OP_LDR, OP_RSVD));
    if (op == OP_B) begin
      w = addr_word(op, 3'($urandom()), prog_target());
    end else if (op == OP_LDR || op == OP_STR) begin
      w = addr_word(op, 3'($urandom()), data_target());
    end else begin
      operand = $urandom_range(0, 1) ? 13'($urandom_range(0, 40)) : 13'($urandom());
      w = alu_word(op, 3'($urandom()), 3'($urandom()), 1'($urandom()), operand);
    end
    w[31:24] = 8'($urandom());
    return w;
  endfunction

  // Offer one command beat, opening a gap first when the burst is used up.
  task automatic send_command(input logic [2:0] cmd, input logic [PortAddrW-1:0] addr,
                              input logic [31:0] word, input logic [2:0] ridx);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    opcode_i    <= cmd;
    address_i   <= addr;
    data_i      <= word;
    reg_index_i <= ridx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    accepted_beats++;
  endtask

  // Result side: segments of differing stall patterns, plus one long
  // hold-off while commands keep coming so that the core backs up.
  initial begin : result_sink
    int unsigned style;
    int unsigned span;
    bit          squeezed;
    squeezed = 1'b0;
    @(posedge rst_ni);
    forever begin
      style = $urandom_range(0, 7);
      span  = (style == 7) ? $urandom_range(4, 40) : $urandom_range(8, 120);
      repeat (span) begin
        @(posedge clk_i);
        if (!squeezed && accepted_beats >= SqueezeAt) begin
          squeezed = 1'b1;
          out_ready_i <= 1'b0;
          repeat (SqueezeCycles) @(posedge clk_i);
        end else begin
          case (style)
            0, 1, 2: out_ready_i <= 1'b1;
            3, 4:    out_ready_i <= 1'($urandom());
            5:       out_ready_i <= ($urandom_range(0, 3) != 0);
            6:       out_ready_i <= ($urandom_range(0, 7) == 0);
            default: out_ready_i <= 1'b0;
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    logic [2:0]           cmd;
    logic [31:0]          word;
    logic [PortAddrW-1:0] addr;
    int unsigned          pick;
    int unsigned          counted;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    opcode_i       = CMD_STEP;
    address_i      = '0;
    data_i         = '0;
    reg_index_i    = '0;
    accepted_beats = 0;
    burst_left     = 0;
    counted        = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Write the program area and the data area. Fetches, branches and loads
    // stay inside them, so no read touches an unwritten word. The last
    // program word jumps back to the start; the top two words carry the
    // data extremes.
    for (int unsigned a = 0; a < ProgWords; a++) begin
      if (a < OpeningLen) begin
        word = opening_word(a);
      end else if (a == ProgWords - 1) begin
        word = addr_word(OP_B, COND_ALWAYS, 17'd0);
      end else begin
        word = random_word();
      end
      send_command(CMD_WRITE_MEM, PortAddrW'(a), word, 3'($urandom()));
    end
    for (int unsigned a = DataBase; a < MemWords; a++) begin
      if (a == MemWords - 1) begin
        word = 32'h8000_0000;
      end else if (a == MemWords - 2) begin
        word = 32'h7fff_ffff;
      end else begin
        word = $urandom();
      end
      send_command(CMD_WRITE_MEM, PortAddrW'(a), word, 3'($urandom()));
    end

    // Directed part: reset values, both address extremes, the opening
    // program, its register and memory effects, and the unused codes.
    send_command(CMD_READ_REG, PortAddrW'($urandom()), $urandom(), 3'd0);
    send_command(CMD_SET_PC, '1, $urandom(), 3'($urandom()));
    send_command(CMD_SET_PC, '0, $urandom(), 3'($urandom()));
    repeat (OpeningSteps) begin
      send_command(CMD_STEP, PortAddrW'($urandom()), $urandom(), 3'($urandom()));
    end
    send_command(CMD_READ_REG, PortAddrW'($urandom()), $urandom(), 3'd0);
    send_command(CMD_READ_REG, PortAddrW'($urandom()), $urandom(), 3'd3);
    send_command(CMD_READ_REG, PortAddrW'($urandom()), $urandom(), 3'd5);
    send_command(CMD_READ_REG, PortAddrW'($urandom()), $urandom(), 3'd7);
    send_command(CMD_READ_MEM, '1, $urandom(), 3'($urandom()));
    send_command(CMD_READ_MEM, PortAddrW'(MemWords - 2), $urandom(), 3'($urandom()));
    send_command(CMD_SPARE_LO, PortAddrW'($urandom()), $urandom(), 3'($urandom()));
    send_command(CMD_SPARE_HI, PortAddrW'($urandom()), $urandom(), 3'($urandom()));

    // Random part: mostly steps through the random program in memory,
    // mixed with rewrites, reads, jumps of the program counter and noise.
    // Program words are only rewritten with instructions, raw data goes to
    // the data area, and the final jump of the program is kept.
    while (counted < RandomBeats) begin
      pick = $urandom_range(0, 99);
      word = $urandom();
      addr = PortAddrW'($urandom());
      if (pick < 55) begin
        cmd = CMD_STEP;
      end else if (pick < 70) begin
        cmd = CMD_WRITE_MEM;
        if (pick[0]) begin
          word = random_word();
          addr = PortAddrW'($urandom_range(0, ProgWords - 2));
        end else begin
          addr = PortAddrW'(data_slot());
        end
      end else if (pick < 78) begin
        cmd  = CMD_READ_MEM;
        addr = pick[0] ? PortAddrW'($urandom_range(0, ProgWords - 1)) :
                         PortAddrW'(data_slot());
      end else if (pick < 84) begin
        cmd  = CMD_SET_PC;
        addr = PortAddrW'($urandom_range(0, ProgWords - 1));
      end else if (pick < 95) begin
        cmd = CMD_READ_REG;
      end else begin
        cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      end
      send_command(cmd, addr, word, 3'($urandom()));
      if (pick < 95) begin
        counted++;
      end
    end
    in_valid_i <= 1'b0;

    // Let the outstanding results drain, then give the verdict.
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("educational_isa_cpu_core test passed");
    end else begin
      $display("educational_isa_cpu_core test failed");
    end
    $finish;
  end

endmodule
